// ----- src/ipv6tp_pkg.sv -----
// Types and codes shared by the IPv6 text address parser.
// No dependencies.
package ipv6tp_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] piece0;
    logic [15:0] piece1;
    logic [15:0] piece2;
    logic [15:0] piece3;
    logic [15:0] piece4;
    logic [15:0] piece5;
    logic [15:0] piece6;
    logic [15:0] piece7;
    logic [2:0]  error_code;
    logic        invalid;
  } out_item_t;

  // classified character
  typedef struct packed {
    logic       is_hex;
    logic       is_dec;
    logic       is_colon;
    logic       is_dot;
    logic [3:0] hex_val;
    logic       last;
  } cls_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_COLON,
    PH_HEX,
    PH_IPV4,
    PH_ERR
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_LEAD_COLON,
    ERR_PIECE,
    ERR_COMPRESS,
    ERR_V4_EMPTY,
    ERR_V4_OCTET
  } err_e;

  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChDot   = 8'h2E;

endpackage

// ----- src/ipv6tp_front.sv -----
// Input register of the parser: accepts characters and classifies them.
// Depends on ipv6tp_pkg.
module ipv6tp_front import ipv6tp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output cls_t     q_data_o
);

  logic valid_q, valid_d;
  cls_t cls_q, cls_d;
  logic accept;

  assign in_stall_o = valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_data_o   = cls_q;

  always_comb begin
    logic [7:0] c;
    c = in_item_i.ch;
    cls_d.is_dec   = (c >= 8'h30) && (c <= 8'h39);
    cls_d.is_colon = (c == ChColon);
    cls_d.is_dot   = (c == ChDot);
    cls_d.last     = in_item_i.last;
    cls_d.is_hex   = 1'b1;
    cls_d.hex_val  = 4'd0;
    if (cls_d.is_dec) begin
      cls_d.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      cls_d.hex_val = c[3:0] + 4'd9;
    end else begin
      cls_d.is_hex = 1'b0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (q_push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q <= cls_d;
    end
  end

endmodule

// ----- src/ipv6tp_fifo.sv -----
// Two-entry queue of classified characters between front and back.
// Depends on ipv6tp_pkg.
module ipv6tp_fifo import ipv6tp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cls_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cls_t data_o
);

  cls_t       mem [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

endmodule

// ----- src/ipv6tp_back.sv -----
// Parser core: runs the address grammar one character per cycle while no stalled result
// holds a last character back, finishes the address on the last character and holds the result. Uses ipv6tp_pkg.
module ipv6tp_back import ipv6tp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cls_t      q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef struct packed {
    logic       ok;
    logic [7:0] acc;
  } dec_res_t;

  function automatic dec_res_t dec_step(logic started, logic [7:0] acc, logic [3:0] d);
    dec_res_t   r;
    logic [11:0] v;
    r.ok  = 1'b1;
    r.acc = acc;
    v     = {1'b0, acc, 3'd0} + {3'd0, acc, 1'b0} + {8'd0, d};
    if (!started) begin
      r.acc = {4'd0, d};
    end else if (acc == 8'd0) begin
      r.ok = 1'b0;
    end else if (v > 12'd255) begin
      r.ok = 1'b0;
    end else begin
      r.acc = v[7:0];
    end
    return r;
  endfunction

  logic [15:0] pieces_q [8];
  logic [15:0] pieces_d [8];
  logic [3:0]  pp_q, pp_d, cp_q, cp_d;
  logic        cs_q, cs_d;
  logic [15:0] ha_q, ha_d;
  logic [2:0]  dc_q, dc_d;
  logic [7:0]  da_q, da_d;
  logic        ds_q, ds_d, db_q, db_d;
  logic [2:0]  os_q, os_d;
  phase_e      ph_q, ph_d;
  err_e        eh_q, eh_d;
  logic        ov_q, ov_d;
  out_item_t   out_q, out_d;

  assign q_pop_o     = q_valid_i && (!q_data_i.last || !ov_q || !out_stall_i);
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic [15:0] pc [8];
    logic [15:0] rs [8];
    logic [3:0]  pp, cp, dsh;
    logic        cs, run_hex, ds, db;
    logic [15:0] ha;
    logic [2:0]  dc, os;
    logic [7:0]  da;
    logic [4:0]  lim;
    phase_e      ph;
    err_e        eh;
    dec_res_t    dr;
    logic        lst;

    pc = pieces_q; pp = pp_q; cp = cp_q; cs = cs_q; ha = ha_q; dc = dc_q;
    da = da_q; ds = ds_q; db = db_q; os = os_q; ph = ph_q; eh = eh_q;
    run_hex = 1'b0;
    lst = q_data_i.last;
    dr = dec_step(ds, da, q_data_i.hex_val);
    rs = pieces_q;
    dsh = 4'd0;
    lim = 5'd0;

    out_d = out_q;
    ov_d  = ov_q && out_stall_i;

    if (q_pop_o) begin
      case (ph)
        PH_START: begin
          if (q_data_i.is_colon) ph = PH_COLON;
          else begin
            ph = PH_HEX;
            run_hex = 1'b1;
          end
        end
        PH_COLON: begin
          if (q_data_i.is_colon) begin
            pp = 4'd1; cp = 4'd1; cs = 1'b1; ph = PH_HEX;
          end else begin
            eh = ERR_LEAD_COLON; ph = PH_ERR;
          end
        end
        PH_HEX: run_hex = 1'b1;
        PH_IPV4: begin
          if (q_data_i.is_dec) begin
            if (!dr.ok) begin
              eh = ERR_V4_OCTET; ph = PH_ERR;
            end else begin
              da = dr.acc; ds = 1'b1;
            end
          end else if (q_data_i.is_dot && ds) begin
            pc[pp[2:0]] = {pc[pp[2:0]][7:0], da};
            os = os + 3'd1;
            if (os == 3'd2 || os == 3'd4) pp = pp + 4'd1;
            da = 8'd0; ds = 1'b0; db = 1'b0;
            if (os >= 3'd4) begin
              eh = ERR_V4_OCTET; ph = PH_ERR;
            end
          end else begin
            eh = ERR_V4_OCTET; ph = PH_ERR;
          end
        end
        default: ;
      endcase

      if (run_hex) begin
        if (dc == 3'd0 && pp >= 4'd8) begin
          eh = ERR_PIECE; ph = PH_ERR;
        end else if (dc == 3'd0 && q_data_i.is_colon) begin
          if (cs) begin
            eh = ERR_COMPRESS; ph = PH_ERR;
          end else begin
            pp = pp + 4'd1; cp = pp; cs = 1'b1;
          end
        end else if (dc < 3'd4 && q_data_i.is_hex) begin
          ha = {ha[11:0], q_data_i.hex_val};
          dc = dc + 3'd1;
          if (!db) begin
            if (!q_data_i.is_dec || !dr.ok) db = 1'b1;
            else begin
              da = dr.acc; ds = 1'b1;
            end
          end
        end else if (q_data_i.is_dot) begin
          if (dc == 3'd0) begin
            eh = ERR_V4_EMPTY; ph = PH_ERR;
          end else if (pp > 4'd6 || db) begin
            eh = ERR_V4_OCTET; ph = PH_ERR;
          end else begin
            ph = PH_IPV4;
            pc[pp[2:0]] = {pc[pp[2:0]][7:0], da};
            os = 3'd1;
            da = 8'd0; ds = 1'b0; db = 1'b0;
          end
        end else if (q_data_i.is_colon && !lst) begin
          pc[pp[2:0]] = ha;
          pp = pp + 4'd1;
          ha = 16'd0; dc = 3'd0; da = 8'd0; ds = 1'b0; db = 1'b0;
        end else begin
          eh = ERR_PIECE; ph = PH_ERR;
        end
      end

      if (lst) begin
        if (ph == PH_COLON) begin
          eh = ERR_LEAD_COLON; ph = PH_ERR;
        end else if (ph == PH_HEX && dc != 3'd0) begin
          pc[pp[2:0]] = ha;
          pp = pp + 4'd1;
        end else if (ph == PH_IPV4) begin
          if (!ds) begin
            eh = ERR_V4_OCTET; ph = PH_ERR;
          end else begin
            pc[pp[2:0]] = {pc[pp[2:0]][7:0], da};
            os = os + 3'd1;
            if (os == 3'd2 || os == 3'd4) pp = pp + 4'd1;
            if (os != 3'd4) begin
              eh = ERR_V4_OCTET; ph = PH_ERR;
            end
          end
        end
        if (ph != PH_ERR) begin
          if (cs) begin
            dsh = 4'd8 - pp;
            lim = {1'b0, cp} + {1'b0, dsh};
            for (int k = 0; k < 8; k++) begin
              if (4'(k) < cp) rs[k] = pc[k];
              else if (5'(k) >= lim) rs[k] = pc[3'(4'(k) - dsh)];
              else rs[k] = 16'd0;
            end
          end else begin
            rs = pc;
            if (pp != 4'd8) begin
              eh = ERR_COMPRESS; ph = PH_ERR;
            end
          end
        end
        ov_d = 1'b1;
        if (ph == PH_ERR) begin
          out_d = '0;
          out_d.error_code = eh;
          out_d.invalid    = 1'b1;
        end else begin
          out_d.piece0 = rs[0]; out_d.piece1 = rs[1];
          out_d.piece2 = rs[2]; out_d.piece3 = rs[3];
          out_d.piece4 = rs[4]; out_d.piece5 = rs[5];
          out_d.piece6 = rs[6]; out_d.piece7 = rs[7];
          out_d.error_code = ERR_NONE;
          out_d.invalid    = 1'b0;
        end
        for (int k = 0; k < 8; k++) pc[k] = 16'd0;
        pp = 4'd0; cp = 4'd0; cs = 1'b0; ha = 16'd0; dc = 3'd0;
        da = 8'd0; ds = 1'b0; db = 1'b0; os = 3'd0; ph = PH_START; eh = ERR_NONE;
      end
    end

    pieces_d = pc; pp_d = pp; cp_d = cp; cs_d = cs; ha_d = ha; dc_d = dc;
    da_d = da; ds_d = ds; db_d = db; os_d = os; ph_d = ph; eh_d = eh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) pieces_q[k] <= 16'd0;
      pp_q <= 4'd0;
      cp_q <= 4'd0;
      cs_q <= 1'b0;
      ha_q <= 16'd0;
      dc_q <= 3'd0;
      da_q <= 8'd0;
      ds_q <= 1'b0;
      db_q <= 1'b0;
      os_q <= 3'd0;
      ph_q <= PH_START;
      eh_q <= ERR_NONE;
      ov_q <= 1'b0;
    end else begin
      pieces_q <= pieces_d;
      pp_q <= pp_d;
      cp_q <= cp_d;
      cs_q <= cs_d;
      ha_q <= ha_d;
      dc_q <= dc_d;
      da_q <= da_d;
      ds_q <= ds_d;
      db_q <= db_d;
      os_q <= os_d;
      ph_q <= ph_d;
      eh_q <= eh_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

// ----- src/ipv6_text_address_parser.sv -----
// Top level of the IPv6 text address parser: front register, queue, parser core.
// Depends on ipv6tp_pkg, ipv6tp_front, ipv6tp_fifo, ipv6tp_back.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid_i / in_stall_o
//   out     | output    | out_item_t | out_valid_o / out_stall_i
//
// One character per clock sustained while no stalled result holds back a last character.
// A character passes through the front register, the queue and the parser core with its
// output register before its result appears. Reset clears all parse state; a last
// character finishes the address and returns the core to start of text. A stalled result
// holds the core only when it reaches another last character; the front register and
// queue then hold up to three characters before in_stall_o rises.
module ipv6_text_address_parser import ipv6tp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic q_push, q_full, q_pop, q_valid;
  cls_t q_wdata, q_rdata;

  ipv6tp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  ipv6tp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  ipv6tp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
